### rtl/arbu_pkg.sv
`default_nettype none
package arbu_pkg;

  localparam int unsigned PipeLast = 8;
  localparam int unsigned DivStages = 4;

  typedef enum logic [3:0] {
    MODE_COPY      = 4'd0,
    MODE_ALPHA     = 4'd1,
    MODE_DIM_ALPHA = 4'd2,
    MODE_DIM       = 4'd3,
    MODE_GRAY      = 4'd4,
    MODE_GRAY_GLOB = 4'd5,
    MODE_GLOBAL    = 4'd6,
    MODE_AVERAGE   = 4'd7,
    MODE_DEST_A    = 4'd8
  } blend_mode_e;

  localparam logic REG_BLEND_MODE   = 1'b0;
  localparam logic REG_GLOBAL_ALPHA = 1'b1;

  localparam logic [31:0] HalfMask  = 32'h007f7f7f;
  localparam logic [31:0] AlphaMask = 32'hff000000;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  ga;
    logic [31:0] s;
    logic [31:0] d;
    logic [7:0]  y;
    logic [15:0] t;
    logic [7:0]  n;
    logic [15:0] sum_r;
    logic [15:0] sum_g;
    logic [15:0] sum_b;
    logic [31:0] res;
  } pipe_t;

  // exact floor(x/255) for x up to 65279
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return acc[15:8];
  endfunction

  // floor(x/10) for x below 2048
  function automatic logic [7:0] div10(input logic [10:0] x);
    logic [23:0] prod;
    prod = {13'd0, x} * 24'd6554;
    return prod[23:16];
  endfunction

  function automatic logic [31:0] halve(input logic [31:0] p);
    return (p >> 1) & HalfMask;
  endfunction

endpackage
`default_nettype wire

### rtl/argb_raster_blend_unit.sv
// an accepted request passes through pipeline registers p_q[0] to p_q[8] before its result is on m_axis
// throughput: one pixel per cycle; the output stall holds the whole pipeline
// the weight division for dest-alpha mode runs in a 4-stage divider, 2 bits a stage
// reset: asynchronous, active low; clears all valid bits, blend_mode to copy,
// global_alpha to 255
`default_nettype none
module argb_raster_blend_unit import arbu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // src_pixel [31:0], dest_pixel [63:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // new_dest_pixel [31:0]
);
  logic [3:0] mode_q;
  logic [7:0] ga_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_COPY;
      ga_q   <= 8'hff;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BLEND_MODE:   mode_q <= cfg_data_i[3:0];
        REG_GLOBAL_ALPHA: ga_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pipe_t p_q [PipeLast+1];
  pipe_t p_d [PipeLast+1];
  logic [PipeLast:0] v_q;
  logic en;
  logic [7:0] w_div;

  assign en = !v_q[PipeLast] || m_axis_tready;
  assign s_axis_tready = en;

  arbu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .dividend_i ({p_q[2].s[31:24], 8'd0} - {8'd0, p_q[2].s[31:24]}),
    .divisor_i  (p_q[2].n),
    .quot_o     (w_div)
  );

  always_comb begin
    pipe_t x;
    logic [7:0] a, w, yr, yg, yb, dr, dg, db, sr, sg, sb;
    logic [23:0] sc;
    logic [31:0] hs;
    logic [31:0] mixp;

    // stage 0: capture request and configuration
    x = '0;
    x.mode = mode_q;
    x.ga   = ga_q;
    x.s    = s_axis_tdata[31:0];
    x.d    = s_axis_tdata[63:32];
    p_d[0] = x;

    // stage 1: luminance and alpha composition product
    x = p_q[0];
    yr = div10({2'b0, x.s[23:16], 1'b0} + {3'b0, x.s[23:16]});
    yg = div10({1'b0, x.s[15:8], 2'b0} + {2'b0, x.s[15:8], 1'b0});
    yb = div10({3'b0, x.s[7:0]});
    x.y = yr + yg + yb;
    x.t = 16'(8'(8'hff - x.s[31:24]) * 8'(8'hff - x.d[31:24]));
    p_d[1] = x;

    // stage 2: composed alpha
    x = p_q[1];
    x.n = 8'hff - div255(x.t);
    p_d[2] = x;

    for (int i = 3; i < 7; i++) p_d[i] = p_q[i-1];

    // stage 7: channel products
    x = p_q[6];
    a = x.s[31:24];
    hs = halve(x.s);
    unique case (x.mode)
      MODE_GRAY_GLOB, MODE_GLOBAL: w = x.ga;
      MODE_DEST_A:                 w = w_div;
      default:                     w = a;
    endcase
    unique case (x.mode)
      MODE_DIM_ALPHA: sc = hs[23:0];
      MODE_GRAY_GLOB: sc = {x.y, x.y, x.y};
      default:        sc = x.s[23:0];
    endcase
    dr = x.d[23:16]; dg = x.d[15:8]; db = x.d[7:0];
    sr = sc[23:16];  sg = sc[15:8];  sb = sc[7:0];
    x.sum_r = 16'(dr * 8'(8'hff - w)) + 16'(sr * w);
    x.sum_g = 16'(dg * 8'(8'hff - w)) + 16'(sg * w);
    x.sum_b = 16'(db * 8'(8'hff - w)) + 16'(sb * w);
    p_d[7] = x;

    // stage 8: normalise and pick the result
    x = p_q[7];
    a = x.s[31:24];
    mixp = {(x.mode == MODE_DEST_A) ? x.n : x.d[31:24],
            div255(x.sum_r), div255(x.sum_g), div255(x.sum_b)};
    unique case (x.mode)
      MODE_COPY:      x.res = x.s;
      MODE_ALPHA:     x.res = (a == 8'hff) ? ((x.d & AlphaMask) | x.s)
                            : (a != 8'd0) ? mixp : x.d;
      MODE_DIM_ALPHA: x.res = (a == 8'hff) ? ((x.s & AlphaMask) | halve(x.s))
                            : (a != 8'd0) ? mixp : x.d;
      MODE_DIM:       x.res = (x.s & AlphaMask) | halve(x.s);
      MODE_GRAY:      x.res = {a, x.y, x.y, x.y};
      MODE_GRAY_GLOB, MODE_GLOBAL: x.res = mixp;
      MODE_AVERAGE:   x.res = x.d - halve(x.d) + halve(x.s);
      MODE_DEST_A:    x.res = (a == 8'hff) ? x.s : (a != 8'd0) ? mixp : x.d;
      default:        x.res = x.d;
    endcase
    p_d[8] = x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PipeLast-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= PipeLast; i++) p_q[i] <= p_d[i];
    end
  end

  assign m_axis_tvalid = v_q[PipeLast];
  assign m_axis_tdata  = p_q[PipeLast].res;
endmodule
`default_nettype wire

### rtl/arbu_div.sv
`default_nettype none
module arbu_div import arbu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [7:0]  divisor_i,
  output logic      [7:0]  quot_o
);
  // restoring division, two quotient bits per stage; quotient assumed below 256
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] dvs;
    logic [7:0] quo;
  } div_t;

  div_t st_q [DivStages];
  div_t st_d [DivStages];

  function automatic div_t two_steps(input div_t x);
    div_t    r;
    logic [8:0] tr;
    r = x;
    for (int k = 0; k < 2; k++) begin
      tr = {r.rem, r.low[7]};
      r.low = {r.low[6:0], 1'b0};
      if (tr >= {1'b0, r.dvs}) begin
        tr = tr - {1'b0, r.dvs};
        r.quo = {r.quo[6:0], 1'b1};
      end else begin
        r.quo = {r.quo[6:0], 1'b0};
      end
      r.rem = tr[7:0];
    end
    return r;
  endfunction

  always_comb begin
    div_t init;
    init.rem = dividend_i[15:8];
    init.low = dividend_i[7:0];
    init.dvs = divisor_i;
    init.quo = 8'd0;
    st_d[0] = two_steps(init);
    for (int i = 1; i < DivStages; i++) st_d[i] = two_steps(st_q[i-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages; i++) st_q[i] <= '0;
    end else if (en_i) begin
      for (int i = 0; i < DivStages; i++) st_q[i] <= st_d[i];
    end
  end

  assign quot_o = st_q[DivStages-1].quo;
endmodule
`default_nettype wire

### rtl/arbu_checker.sv
`default_nettype none
module arbu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  // the input side only waits while the output side stalls
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input stalled without output stall");

  // an offered result carries defined data
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown(m_axis_tdata))
    else $error("result with undefined data");
endmodule

bind argb_raster_blend_unit arbu_checker u_arbu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

### bench/argb_raster_blend_unit_chk.sv
`default_nettype none
module argb_raster_blend_unit_chk import arbu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  output int               fail_cnt_o,
  output int               pending_o
);

  logic [3:0]  mode_q;
  logic [7:0]  galpha_q;
  logic [31:0] pixel_q[$];

  assign pending_o = pixel_q.size();

  function automatic logic [7:0] mix_ch(logic [7:0] d, logic [7:0] s, logic [8:0] a);
    int unsigned v;
    v = (d * (255 - a) + s * a) / 255;
    return v[7:0];
  endfunction

  function automatic logic [31:0] mix_px(logic [31:0] d, logic [31:0] s, logic [8:0] a);
    return {d[31:24], mix_ch(d[23:16], s[23:16], a), mix_ch(d[15:8], s[15:8], a),
            mix_ch(d[7:0], s[7:0], a)};
  endfunction

  function automatic logic [31:0] half_px(logic [31:0] p);
    return (p >> 1) & 32'h007f7f7f;
  endfunction

  function automatic logic [31:0] luma_px(logic [31:0] s);
    int unsigned y;
    y = 3 * s[23:16] / 10 + 6 * s[15:8] / 10 + s[7:0] / 10;
    return {s[31:24], y[7:0], y[7:0], y[7:0]};
  endfunction

  function automatic logic [31:0] blended_pixel(logic [31:0] s, logic [31:0] d);
    int unsigned a, da, n, w;
    logic [31:0] r;
    a = 32'(s[31:24]);
    r = d;
    case (mode_q)
      MODE_COPY: r = s;
      MODE_ALPHA:
        if (a == 255) r = (d & 32'hff000000) | s;
        else if (a != 0) r = mix_px(d, s, 9'(a));
      MODE_DIM_ALPHA:
        if (a == 255) r = {s[31:24], 24'd0} | half_px(s);
        else if (a != 0) r = mix_px(d, half_px(s), 9'(a));
      MODE_DIM: r = {s[31:24], 24'd0} | half_px(s);
      MODE_GRAY: r = luma_px(s);
      MODE_GRAY_GLOB: r = mix_px(d, luma_px(s), {1'b0, galpha_q});
      MODE_GLOBAL: r = mix_px(d, s, {1'b0, galpha_q});
      MODE_AVERAGE: r = d - half_px(d) + half_px(s);
      MODE_DEST_A:
        if (a == 255) r = s;
        else if (a != 0) begin
          da = 32'(d[31:24]);
          n = 255 - (255 - a) * (255 - da) / 255;
          w = a;
          if (n != 0) w = a * 255 / n;
          if (w > 255) w = 255;
          r = mix_px({n[7:0], d[23:0]}, s, 9'(w));
        end
      default: r = d;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_COPY;
      galpha_q <= 8'd255;
      fail_cnt_o <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_BLEND_MODE) mode_q <= cfg_data_i[3:0];
        else galpha_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        pixel_q.push_back(blended_pixel(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) report("unexpected request", m_axis_tdata, 32'd0);
        else if (m_axis_tdata !== pixel_q[0])
          report("new_dest_pixel", m_axis_tdata, pixel_q.pop_front());
        else void'(pixel_q.pop_front());
      end
    end
  end

endmodule
`default_nettype wire

### bench/argb_raster_blend_unit_tb.sv
`default_nettype none
module argb_raster_blend_unit_tb import arbu_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_cnt, pending;
  bit          stall_on = 1'b1;

  always #5 clk_i = ~clk_i;

  argb_raster_blend_unit u_dut (.*);

  argb_raster_blend_unit_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // while stall_on is set the receiver stalls in phases: long free stretches, then random back-pressure
  always @(posedge clk_i) begin
    int unsigned ph;
    ph = 32'($time / 64'd10);
    if (ph % 400 < 100 || !stall_on) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_pixel(logic [31:0] s, logic [31:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {d, s};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hff;
      2: p = {$urandom_range(0, 1) ? 8'h00 : 8'hff, 24'hffffff};
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    logic [31:0] dir_px[6];
    int burst;
    dir_px = '{32'h00000000, 32'hffffffff, 32'h80ff00ff, 32'h01000000,
               32'hfe7f807f, 32'hff123456};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: each mode with extremes, alpha 0, 255 and mid values
    for (int m = 0; m < 11; m++) begin
      write_reg(REG_BLEND_MODE, (m == 10) ? 8'hff : m[7:0]);
      write_reg(REG_GLOBAL_ALPHA, (m % 2) ? 8'd0 : 8'd128);
      send_pixel(dir_px[m % 6], dir_px[(m + 1) % 6]);
      send_pixel(dir_px[(m + 2) % 6], dir_px[(m + 4) % 6]);
    end
    // random phases over all modes and global alpha extremes
    for (int ph = 0; ph < 15; ph++) begin
      stall_on = (ph % 4 != 0);
      write_reg(REG_BLEND_MODE, (ph < 9) ? ph[7:0] : 8'($urandom_range(0, 15)));
      write_reg(REG_GLOBAL_ALPHA, (ph % 3 == 0) ? 8'd0 : (ph % 3 == 1) ? 8'd255 :
                8'($urandom_range(0, 255)));
      for (int k = 0; k < 45; k += burst) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst; j++) send_pixel(rand_pixel(), rand_pixel());
        if ($urandom_range(0, 2) != 0) idle_gap();
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
